@@ rtl/core/cddd_pkg.sv @@
// ----------------------------------------------------------------------------
// cddd_pkg: shared types and calendar helpers
// Field widths, sequencer states and Gregorian month-length / leap logic.
// ----------------------------------------------------------------------------
package cddd_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned REM_W   = 9;   // holds year mod 400
  localparam int unsigned COUNT_W = 22;

  localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
  localparam logic [YEAR_W-1:0]  LEAP_CYCLE = 14'd400;
  localparam logic [REM_W-1:0]   REM_LAST   = 9'd399;
  localparam logic [MONTH_W-1:0] JANUARY    = 4'd1;
  localparam logic [MONTH_W-1:0] FEBRUARY   = 4'd2;
  localparam logic [MONTH_W-1:0] DECEMBER   = 4'd12;
  localparam logic [DAY_W-1:0]   FIRST_DAY  = 5'd1;
  localparam logic [DAY_W-1:0]   DAYS_31    = 5'd31;
  localparam logic [DAY_W-1:0]   DAYS_30    = 5'd30;
  localparam logic [DAY_W-1:0]   DAYS_29    = 5'd29;
  localparam logic [DAY_W-1:0]   DAYS_28    = 5'd28;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REM_FIRST,
    ST_REM_SECOND,
    ST_CHECK,
    ST_STEP
  } state_e;

  // Leap rule from year mod 400: mod 4 is the low two bits of the remainder,
  // century years other than the 400th are excluded.
  function automatic logic is_leap(input logic [REM_W-1:0] rem);
    logic cent;
    cent = (rem == 9'd100) || (rem == 9'd200) || (rem == 9'd300);
    return (rem[1:0] == 2'd0) && !cent;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:    len = leap ? DAYS_29 : DAYS_28;
      4'd4:    len = DAYS_30;
      4'd6:    len = DAYS_30;
      4'd9:    len = DAYS_30;
      4'd11:   len = DAYS_30;
      default: len = DAYS_31;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/core/cddd_rem400.sv @@
// ----------------------------------------------------------------------------
// cddd_rem400: iterative year mod 400
// Shared subtractor; removes 400 per cycle until the remainder is below 400.
// ----------------------------------------------------------------------------
module cddd_rem400 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cddd_pkg::YEAR_W-1:0] year_i,
  output logic                        done_o,
  output logic [cddd_pkg::REM_W-1:0]  rem_o
);

  logic [cddd_pkg::YEAR_W-1:0] r_q, r_d;
  logic                        active_q, active_d;
  logic                        ge;

  assign ge     = (r_q >= cddd_pkg::LEAP_CYCLE);
  assign done_o = active_q && !ge;
  assign rem_o  = r_q[cddd_pkg::REM_W-1:0];

  always_comb begin
    r_d      = r_q;
    active_d = active_q;
    if (start_i) begin
      r_d      = year_i;
      active_d = 1'b1;
    end else if (active_q) begin
      if (ge) begin
        r_d = r_q - cddd_pkg::LEAP_CYCLE;
      end else begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
  end

  // Remainder strictly falls while reducing.
  a_reduce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q && ge && !start_i |=> active_q && (r_q < $past(r_q)))
    else $error("rem400: reduction did not progress");

endmodule

@@ rtl/core/calendar_date_difference_days_core.sv @@
// ----------------------------------------------------------------------------
// calendar_date_difference_days_core: days between two Gregorian dates
// Checks the dates, orders them, then steps the later one back a day per
// cycle until it meets the earlier one, counting the steps.
// ----------------------------------------------------------------------------
//  channel  | signals                         | transfer
//  ---------+---------------------------------+---------------------------------
//  command  | start, busy, first_*_i,        | edge with start high, busy low
//           | second_*_i                      |
//  result   | done_o, day_count_o,            | edge ending the cycle done_o is
//           | first_was_later_o,date_invalid_o| high; one cycle, never held
//
//  Busy is already low in the result cycle. The day-stepping loop, one step
//  per day counted, and the mod-400 reductions of both years set the time per
//  item; the day count is at most 3652058 (0001-01-01 to 9999-12-31).
//  Reset clears the sequencer, the mod-400 unit's active flag and the result
//  strobe; other registers have no reset. The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module calendar_date_difference_days_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [cddd_pkg::DAY_W-1:0]   first_day_i,
  input  logic [cddd_pkg::MONTH_W-1:0] first_month_i,
  input  logic [cddd_pkg::YEAR_W-1:0]  first_year_i,
  input  logic [cddd_pkg::DAY_W-1:0]   second_day_i,
  input  logic [cddd_pkg::MONTH_W-1:0] second_month_i,
  input  logic [cddd_pkg::YEAR_W-1:0]  second_year_i,
  output logic                         done_o,
  output logic [cddd_pkg::COUNT_W-1:0] day_count_o,
  output logic                         first_was_later_o,
  output logic                         date_invalid_o
);

  localparam int unsigned KEY_W = cddd_pkg::YEAR_W + cddd_pkg::MONTH_W + cddd_pkg::DAY_W;

  cddd_pkg::state_e state_q, state_d;

  // captured command
  logic [cddd_pkg::DAY_W-1:0]   d1_q, d2_q;
  logic [cddd_pkg::MONTH_W-1:0] m1_q, m2_q;
  logic [cddd_pkg::YEAR_W-1:0]  y1_q, y2_q;
  logic [cddd_pkg::REM_W-1:0]   r1_q, r1_d;

  // walking date (the later one) and target (the earlier one)
  logic [cddd_pkg::DAY_W-1:0]   cur_d_q, cur_d_d;
  logic [cddd_pkg::MONTH_W-1:0] cur_m_q, cur_m_d;
  logic [cddd_pkg::YEAR_W-1:0]  cur_y_q, cur_y_d;
  logic [cddd_pkg::REM_W-1:0]   cur_r_q, cur_r_d;
  logic [KEY_W-1:0]             tgt_q, tgt_d;
  logic [cddd_pkg::COUNT_W-1:0] cnt_q, cnt_d;
  logic                         later_q, later_d;

  // result register
  logic                         done_q, done_d;
  logic [cddd_pkg::COUNT_W-1:0] count_q, count_d;
  logic                         fwl_q, fwl_d;
  logic                         inv_q, inv_d;

  logic                         accept;
  logic                         rem_start, rem_done;
  logic [cddd_pkg::YEAR_W-1:0]  rem_year;
  logic [cddd_pkg::REM_W-1:0]   rem_val;

  logic [KEY_W-1:0]             key1, key2, cur_key, prev_key;
  logic                         ok1, ok2;
  logic [cddd_pkg::DAY_W-1:0]   prev_d;
  logic [cddd_pkg::MONTH_W-1:0] prev_m;
  logic [cddd_pkg::YEAR_W-1:0]  prev_y;
  logic [cddd_pkg::REM_W-1:0]   prev_r;

  assign accept = start && !busy;
  assign busy   = (state_q != cddd_pkg::ST_IDLE);

  cddd_rem400 u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rem_start),
    .year_i  (rem_year),
    .done_o  (rem_done),
    .rem_o   (rem_val)
  );

  // Year mod 400 of the first date is taken straight from the port at the
  // transfer; the second year follows once the first is done.
  assign rem_start = accept || ((state_q == cddd_pkg::ST_REM_FIRST) && rem_done);
  assign rem_year  = accept ? first_year_i : y2_q;

  assign key1    = {y1_q, m1_q, d1_q};
  assign key2    = {y2_q, m2_q, d2_q};
  assign cur_key = {cur_y_q, cur_m_q, cur_d_q};

  // Validity of each date; rem_val is the second year's remainder in CHECK's
  // predecessor cycle, so it is held in cur_r_q by then (see ST_REM_SECOND).
  assign ok1 = (y1_q >= cddd_pkg::YEAR_MIN) && (y1_q <= cddd_pkg::YEAR_MAX) &&
               (m1_q >= cddd_pkg::JANUARY) && (m1_q <= cddd_pkg::DECEMBER) &&
               (d1_q >= cddd_pkg::FIRST_DAY) &&
               (d1_q <= cddd_pkg::month_len(m1_q, cddd_pkg::is_leap(r1_q)));
  assign ok2 = (y2_q >= cddd_pkg::YEAR_MIN) && (y2_q <= cddd_pkg::YEAR_MAX) &&
               (m2_q >= cddd_pkg::JANUARY) && (m2_q <= cddd_pkg::DECEMBER) &&
               (d2_q >= cddd_pkg::FIRST_DAY) &&
               (d2_q <= cddd_pkg::month_len(m2_q, cddd_pkg::is_leap(cur_r_q)));

  // Previous calendar day of the walking date.
  always_comb begin
    prev_d = cur_d_q;
    prev_m = cur_m_q;
    prev_y = cur_y_q;
    prev_r = cur_r_q;
    if (cur_d_q != cddd_pkg::FIRST_DAY) begin
      prev_d = cur_d_q - 5'd1;
    end else if (cur_m_q != cddd_pkg::JANUARY) begin
      prev_m = cur_m_q - 4'd1;
      prev_d = cddd_pkg::month_len(cur_m_q - 4'd1, cddd_pkg::is_leap(cur_r_q));
    end else begin
      prev_y = cur_y_q - 14'd1;
      prev_m = cddd_pkg::DECEMBER;
      prev_d = cddd_pkg::DAYS_31;
      prev_r = (cur_r_q == '0) ? cddd_pkg::REM_LAST : cur_r_q - 9'd1;
    end
  end

  assign prev_key = {prev_y, prev_m, prev_d};

  always_comb begin
    state_d = state_q;
    r1_d    = r1_q;
    cur_d_d = cur_d_q;
    cur_m_d = cur_m_q;
    cur_y_d = cur_y_q;
    cur_r_d = cur_r_q;
    tgt_d   = tgt_q;
    cnt_d   = cnt_q;
    later_d = later_q;
    done_d  = 1'b0;
    count_d = count_q;
    fwl_d   = fwl_q;
    inv_d   = inv_q;
    case (state_q)
      cddd_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = cddd_pkg::ST_REM_FIRST;
        end
      end
      cddd_pkg::ST_REM_FIRST: begin
        if (rem_done) begin
          r1_d    = rem_val;
          state_d = cddd_pkg::ST_REM_SECOND;
        end
      end
      cddd_pkg::ST_REM_SECOND: begin
        if (rem_done) begin
          cur_r_d = rem_val;   // second year's remainder, parked for CHECK
          state_d = cddd_pkg::ST_CHECK;
        end
      end
      cddd_pkg::ST_CHECK: begin
        cnt_d = '0;
        if (!ok1 || !ok2) begin
          done_d  = 1'b1;
          count_d = '0;
          fwl_d   = 1'b0;
          inv_d   = 1'b1;
          state_d = cddd_pkg::ST_IDLE;
        end else if (key1 == key2) begin
          done_d  = 1'b1;
          count_d = '0;
          fwl_d   = 1'b0;
          inv_d   = 1'b0;
          state_d = cddd_pkg::ST_IDLE;
        end else begin
          later_d = (key1 > key2);
          if (key1 > key2) begin
            cur_d_d = d1_q;
            cur_m_d = m1_q;
            cur_y_d = y1_q;
            cur_r_d = r1_q;
            tgt_d   = key2;
          end else begin
            cur_d_d = d2_q;
            cur_m_d = m2_q;
            cur_y_d = y2_q;
            tgt_d   = key1;
          end
          state_d = cddd_pkg::ST_STEP;
        end
      end
      cddd_pkg::ST_STEP: begin
        cur_d_d = prev_d;
        cur_m_d = prev_m;
        cur_y_d = prev_y;
        cur_r_d = prev_r;
        cnt_d   = cnt_q + 22'd1;
        if (prev_key == tgt_q) begin
          done_d  = 1'b1;
          count_d = cnt_q + 22'd1;
          fwl_d   = later_q;
          inv_d   = 1'b0;
          state_d = cddd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cddd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cddd_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      d1_q <= first_day_i;
      m1_q <= first_month_i;
      y1_q <= first_year_i;
      d2_q <= second_day_i;
      m2_q <= second_month_i;
      y2_q <= second_year_i;
    end
    r1_q    <= r1_d;
    cur_d_q <= cur_d_d;
    cur_m_q <= cur_m_d;
    cur_y_q <= cur_y_d;
    cur_r_q <= cur_r_d;
    tgt_q   <= tgt_d;
    cnt_q   <= cnt_d;
    later_q <= later_d;
    count_q <= count_d;
    fwl_q   <= fwl_d;
    inv_q   <= inv_d;
  end

  assign done_o            = done_q;
  assign day_count_o       = count_q;
  assign first_was_later_o = fwl_q;
  assign date_invalid_o    = inv_q;

  // Invalid dates always report a zero count and no ordering.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && date_invalid_o |-> (day_count_o == '0) && !first_was_later_o)
    else $error("invalid date reported with nonzero fields");

  // The result cycle always follows the sequencer's return to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // The walking date never sits on the target while stepping.
  a_walk_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cddd_pkg::ST_STEP |-> cur_key != tgt_q)
    else $error("walking date reached target without finishing");

  // A command transfer starts the mod-400 phase.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == cddd_pkg::ST_REM_FIRST)
    else $error("command transfer did not start the sequence");

endmodule
